/* hdl/lru_key_value_cache_assert.svh */
// assertion macros for the lru key-value cache
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, off while reset is low
`define LKVC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lkvc assertion failed");
// checked property, also during reset
`define LKVC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT(name, prop)
`define LKVC_ASSERT_ALWAYS(name, prop)
`endif
`endif

/* hdl/lkvc_pkg.sv */
// shared constants, types and state encoding of the lru key-value cache
package lkvc_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 48;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);
  localparam int CAP_BITS   = 5;
  localparam int CMP_BITS   = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic search;
    logic load_out;
  } cmd_t;

endpackage

/* hdl/lkvc_ram.sv */
// generic single-write, single-read ram with registered read data
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/lkvc_ctrl.sv */
// control state machine of the lru key-value cache
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: state_d = ST_READ;
      ST_READ:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:   cmd_o.capture  = in_valid_i;
      ST_SEARCH: cmd_o.search   = 1'b1;
      ST_READ:   cmd_o          = '0;
      ST_DONE:   cmd_o.load_out = out_free;
      default:   cmd_o          = '0;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  // a result beat stays until taken; a new one loads once it is gone
  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hdl/lkvc_dp.sv */
// datapath: key compare, recency ranks, value store and result register
module lkvc_dp import lkvc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic                  cfg_we_i,
  input  logic [CAP_BITS-1:0]   cfg_wdata_i,
  input  logic                  opcode_i,
  input  logic [KEY_BITS-1:0]   lookup_key_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  output logic                  hit_o,
  output logic [VALUE_BITS-1:0] read_value_o,
  output logic                  evicted_o
);

  logic [CAP_BITS-1:0]   cap_q;
  logic                  op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [KEY_BITS-1:0]   entry_key_q  [ENTRIES];
  logic [ENTRIES-1:0]    entry_valid_q;
  logic [IDX_BITS-1:0]   rank_q       [ENTRIES];
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [IDX_BITS-1:0]   slot_q, slot_d;
  logic                  res_hit_q, res_ev_q, res_rd_q;

  logic [ENTRIES-1:0]    match, victim;
  logic                  hit, full, free_found, hit_found, vic_found;
  logic [IDX_BITS-1:0]   hit_idx, free_idx, vic_idx;
  logic [CMP_BITS-1:0]   cap_eff;
  logic [CNT_BITS-1:0]   cnt_m1, thresh;
  logic                  do_update, do_alloc, do_evict, do_key_wr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic                  hit_oq, ev_oq;
  logic [VALUE_BITS-1:0] rd_oq;

  // effective capacity: zero acts as one, too large acts as the store size
  always_comb begin
    cap_eff = CMP_BITS'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CMP_BITS'(1);
    end else if (CMP_BITS'(cap_q) > CMP_BITS'(ENTRIES)) begin
      cap_eff = CMP_BITS'(ENTRIES);
    end
  end

  assign cnt_m1 = count_q - CNT_BITS'(1);
  assign full   = CMP_BITS'(count_q) >= cap_eff;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = entry_valid_q[i] && (entry_key_q[i] == key_q);
      // lru entry holds the highest rank, which is count minus one
      victim[i] = entry_valid_q[i] && (rank_q[i] == cnt_m1[IDX_BITS-1:0]);
    end
  end

  always_comb begin
    hit_found  = 1'b0;
    vic_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    vic_idx    = '0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i] && !hit_found) begin
        hit_found = 1'b1;
        hit_idx   = IDX_BITS'(i);
      end
      if (victim[i] && !vic_found) begin
        vic_found = 1'b1;
        vic_idx   = IDX_BITS'(i);
      end
      if (!entry_valid_q[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IDX_BITS'(i);
      end
    end
  end

  assign hit       = hit_found;
  assign do_update = cmd_i.search && (hit || (op_q == OP_INSERT));
  assign do_key_wr = cmd_i.search && !hit && (op_q == OP_INSERT);
  assign do_evict  = do_key_wr && full;
  assign do_alloc  = do_key_wr && !full;

  // target slot and the rank below which entries age by one
  always_comb begin
    if (hit) begin
      slot_d = hit_idx;
      thresh = CNT_BITS'(rank_q[hit_idx]);
    end else if (full) begin
      slot_d = vic_idx;
      thresh = cnt_m1;
    end else begin
      slot_d = free_idx;
      thresh = count_q;
    end
  end

  assign count_d = do_alloc ? count_q + CNT_BITS'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q         <= CAP_RESET;
      entry_valid_q <= '0;
      count_q       <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      count_q <= count_d;
      if (do_alloc) entry_valid_q[slot_d] <= 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_update) begin
          if (IDX_BITS'(i) == slot_d) begin
            rank_q[i] <= '0;
          end else if (entry_valid_q[i] && (CNT_BITS'(rank_q[i]) < thresh)) begin
            rank_q[i] <= rank_q[i] + IDX_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      key_q <= lookup_key_i;
      val_q <= new_value_i;
    end
    if (cmd_i.search) begin
      slot_q    <= slot_d;
      res_hit_q <= hit;
      res_ev_q  <= do_evict;
      res_rd_q  <= hit && (op_q == OP_LOOKUP);
    end
    if (do_key_wr) entry_key_q[slot_d] <= key_q;
    if (cmd_i.load_out) begin
      hit_oq <= res_hit_q;
      ev_oq  <= res_ev_q;
      rd_oq  <= res_rd_q ? ram_rdata : '0;
    end
  end

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.search && (op_q == OP_INSERT)),
    .waddr_i (slot_d),
    .wdata_i (val_q),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  assign hit_o        = hit_oq;
  assign evicted_o    = ev_oq;
  assign read_value_o = rd_oq;

endmodule

/* hdl/lru_key_value_cache.sv */
// top level of the lru key-value cache
// each accepted item passes capture, key search and rank update, value ram read
// and result load in turn, the value ram's registered read giving the read step;
// a new item is taken only once the result is loaded, and a stalled result beat
// holds the load back; the next item is taken while the previous result beat still waits
// reset: valid bits, ranks, fill count and capacity (16) clear at once, no sweep
module lru_key_value_cache import lkvc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CAP_BITS-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic [KEY_BITS-1:0]   lookup_key_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [VALUE_BITS-1:0] read_value_o,
  output logic                  evicted_o
);

`include "lru_key_value_cache_assert.svh"

  cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lkvc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .opcode_i     (opcode_i),
    .lookup_key_i (lookup_key_i),
    .new_value_i  (new_value_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o)
  );

  // an accepted beat closes the input until its result is loaded
  `LKVC_ASSERT(a_stall_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // a hit never evicts
  `LKVC_ASSERT(a_hit_not_evict, out_valid_o |-> !(hit_o && evicted_o))
  // nonzero read data only comes from a hit
  `LKVC_ASSERT(a_data_needs_hit, (out_valid_o && (read_value_o != '0)) |-> hit_o)
  // nothing is presented straight out of reset
  `LKVC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o)

endmodule

/* tb/sv/lru_cache_checker.sv */
// channel monitor, lru cache predictor and result comparison for the key-value cache
module lru_cache_checker import lkvc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CAP_BITS-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  opcode_i,
  input  logic [KEY_BITS-1:0]   lookup_key_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  hit_i,
  input  logic [VALUE_BITS-1:0] read_value_i,
  input  logic                  evicted_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
  } cache_result_t;

  logic [KEY_BITS-1:0]   shadow_key   [ENTRIES];
  logic [VALUE_BITS-1:0] shadow_value [ENTRIES];
  logic                  shadow_valid [ENTRIES];
  int unsigned           shadow_rank  [ENTRIES];
  int unsigned           shadow_fill;
  logic [CAP_BITS-1:0]   shadow_capacity;

  cache_result_t expected_results [$];
  cache_result_t oldest;
  int            mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  // slot becomes most recent, everything more recent than it ages by one
  function automatic void make_most_recent(int slot, int unsigned old_rank);
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_valid[i] && i != slot && shadow_rank[i] < old_rank)
        shadow_rank[i]++;
    shadow_rank[slot] = 0;
  endfunction

  function automatic cache_result_t predict_access(logic op, logic [KEY_BITS-1:0] key,
                                                   logic [VALUE_BITS-1:0] value);
    cache_result_t res;
    int unsigned   limit;
    int            slot;
    bit            present;
    res     = '0;
    present = 1'b0;
    slot    = -1;
    limit   = shadow_capacity;
    if (limit == 0) limit = 1;
    if (limit > ENTRIES) limit = ENTRIES;

    for (int i = 0; i < ENTRIES; i++)
      if (!present && shadow_valid[i] && shadow_key[i] == key) begin
        present = 1'b1;
        slot    = i;
      end

    if (present) begin
      res.hit = 1'b1;
      if (op == OP_LOOKUP) res.read_value = shadow_value[slot];
      else shadow_value[slot] = value;
      make_most_recent(slot, shadow_rank[slot]);
    end else if (op == OP_INSERT) begin
      if (shadow_fill >= limit) begin
        // replace the oldest valid entry, fill stays put even above capacity
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > shadow_rank[slot]))
            slot = i;
        res.evicted = 1'b1;
        make_most_recent(slot, shadow_rank[slot]);
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !shadow_valid[i]) slot = i;
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i]) shadow_rank[i]++;
        shadow_rank[slot]  = 0;
        shadow_valid[slot] = 1'b1;
        shadow_fill++;
      end
      shadow_key[slot]   = key;
      shadow_value[slot] = value;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_key[i]   = '0;
        shadow_value[i] = '0;
        shadow_valid[i] = 1'b0;
        shadow_rank[i]  = 0;
      end
      shadow_fill     = 0;
      shadow_capacity = CAP_RESET;
      expected_results.delete();
      pending_o = 0;
    end else begin
      // result beat first: it was on the port before this edge's request
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result beat: hit %0d read_value %h evicted %0d",
                   $time, hit_i, read_value_i, evicted_i);
        end else begin
          oldest = expected_results.pop_front();
          if (hit_i !== oldest.hit) begin
            mismatch_count++;
            $display("%0t hit mismatch: expected %0d actual %0d", $time, oldest.hit, hit_i);
          end
          if (read_value_i !== oldest.read_value) begin
            mismatch_count++;
            $display("%0t read_value mismatch: expected %h actual %h",
                     $time, oldest.read_value, read_value_i);
          end
          if (evicted_i !== oldest.evicted) begin
            mismatch_count++;
            $display("%0t evicted mismatch: expected %0d actual %0d",
                     $time, oldest.evicted, evicted_i);
          end
        end
      end
      if (cfg_we_i) shadow_capacity = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        expected_results = {expected_results,
                            predict_access(opcode_i, lookup_key_i, new_value_i)};
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/sv/tb_lru_key_value_cache.sv */
// stimulus, clock, reset and verdict for the lru key-value cache
module tb_lru_key_value_cache import lkvc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int WATCHDOG_LIMIT  = 3000;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CAP_BITS-1:0]   cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  opcode_i     = OP_LOOKUP;
  logic [KEY_BITS-1:0]   lookup_key_i = '0;
  logic [VALUE_BITS-1:0] new_value_i  = '0;
  logic                  out_stall_i  = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  hit_o;
  logic [VALUE_BITS-1:0] read_value_o;
  logic                  evicted_o;

  int fail_count;
  int pending_results;
  bit steady = 1'b0;

  lru_key_value_cache uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .lookup_key_i (lookup_key_i),
    .new_value_i  (new_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o)
  );

  lru_cache_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .opcode_i     (opcode_i),
    .lookup_key_i (lookup_key_i),
    .new_value_i  (new_value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_i        (hit_o),
    .read_value_i (read_value_o),
    .evicted_i    (evicted_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_BITS-1:0] rand_key();
    return KEY_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic [VALUE_BITS-1:0] rand_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VALUE_BITS'($urandom);
  endfunction

  // valid stays high after the beat so back-to-back requests need no re-raise
  task automatic send_item(logic op, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    lookup_key_i <= key;
    new_value_i  <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] cap);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // receiver stalls
  initial begin
    int hold;
    int run;
    @(posedge rst_ni);
    forever begin
      hold = idle_len();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 5);
      repeat (run + 1) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [CAP_BITS-1:0] cap_plan [NUM_PHASES];
    logic [KEY_BITS-1:0] key_pool [$];
    logic [KEY_BITS-1:0] key;
    int                  pool_size;

    // lowered below fill first, then both clamps and both extremes
    cap_plan[0] = CAP_BITS'(4);
    cap_plan[1] = CAP_BITS'(1);
    cap_plan[2] = CAP_BITS'(0);
    cap_plan[3] = CAP_BITS'(31);
    cap_plan[4] = CAP_BITS'(16);
    cap_plan[5] = CAP_BITS'(2);
    for (int p = 6; p < NUM_PHASES; p++) cap_plan[p] = CAP_BITS'($urandom_range(3, 15));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty miss, key extremes, update, fill and evict at reset capacity
    send_item(OP_LOOKUP, '0, '1);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_INSERT, '1, '1);
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_LOOKUP, '1, '1);
    send_item(OP_INSERT, '0, 32'h1234_5678);
    send_item(OP_LOOKUP, '0, '1);
    send_item(OP_LOOKUP, KEY_BITS'(1), '0);
    for (int i = 0; i < 16; i++)
      send_item(OP_INSERT, KEY_BITS'(64'h5a5a_0000_0000 + i), rand_value());
    send_item(OP_LOOKUP, '1, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(cap_plan[p]);
      steady    = ($urandom_range(0, 3) == 0);
      pool_size = ((cap_plan[p] > 16) ? 16 : cap_plan[p]) + $urandom_range(1, 6);
      // fresh keys replace the whole old pool, so earlier entries are only aged out
      for (int k = 0; k < pool_size; k++) key_pool = {key_pool, rand_key()};
      while (key_pool.size() > pool_size) void'(key_pool.pop_front());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 85)
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
          key = rand_key();
        send_item(logic'($urandom_range(0, 1)), key, rand_value());
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/lkvc_pkg.sv
hdl/lkvc_ram.sv
hdl/lkvc_ctrl.sv
hdl/lkvc_dp.sv
hdl/lru_key_value_cache.sv
tb/sv/lru_cache_checker.sv
tb/sv/tb_lru_key_value_cache.sv
